/* sv/lbs_pkg.sv */
// Shared types, constants and saturation helpers for the skinning engine.
// Used by lbs_row_unit, linear_blend_skinning and the testbench; depends on nothing.
package lbs_pkg;

   localparam int LBS_JOINT_COUNT = 64;
   localparam int LBS_MAT_WORDS   = 12;
   localparam int LBS_JOINT_W     = 6;
   localparam int LBS_ELEM_W      = 4;
   localparam int LBS_WORD_W      = 32;
   localparam int LBS_WEIGHT_W    = 17;
   localparam int LBS_ACC_W       = 48;
   localparam int LBS_SUM_W       = 51;
   localparam int LBS_WPROD_W     = 66;
   localparam int LBS_REQ_DATA_W  = 160;
   localparam int LBS_RSP_DATA_W  = 96;

   localparam logic       LBS_MODE_WRITE = 1'b0;
   localparam logic       LBS_MODE_APPLY = 1'b1;
   localparam logic [1:0] LBS_COL_TRANS  = 2'd3;
   localparam logic [1:0] LBS_COL_FIRST  = 2'd0;
   localparam logic [1:0] LBS_ROW_X      = 2'd0;
   localparam logic [1:0] LBS_ROW_Y      = 2'd1;
   localparam logic [1:0] LBS_ROW_Z      = 2'd2;
   localparam logic [LBS_WEIGHT_W-1:0] LBS_WEIGHT_ONE = 17'd65536;
   localparam logic signed [31:0] LBS_Q16_ONE = 32'sh0001_0000;

   // Tag that travels with one palette word through the datapath.
   typedef struct packed {
      logic       vld;
      logic [1:0] row;
      logic [1:0] col;
   } lbs_tag_type;

   function automatic logic signed [LBS_ACC_W-1:0] sat48(input logic signed [LBS_SUM_W-1:0] v);
      logic signed [LBS_SUM_W-1:0] hi;
      logic signed [LBS_SUM_W-1:0] lo;
      hi = {{(LBS_SUM_W-LBS_ACC_W+1){1'b0}}, {(LBS_ACC_W-1){1'b1}}};
      lo = {{(LBS_SUM_W-LBS_ACC_W+1){1'b1}}, {(LBS_ACC_W-1){1'b0}}};
      if (v > hi) return hi[LBS_ACC_W-1:0];
      else if (v < lo) return lo[LBS_ACC_W-1:0];
      else return v[LBS_ACC_W-1:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [LBS_ACC_W-1:0] v);
      logic signed [LBS_ACC_W-1:0] hi;
      logic signed [LBS_ACC_W-1:0] lo;
      hi = {{(LBS_ACC_W-31){1'b0}}, {31{1'b1}}};
      lo = {{(LBS_ACC_W-31){1'b1}}, {31{1'b0}}};
      if (v > hi) return 32'sh7fff_ffff;
      else if (v < lo) return 32'sh8000_0000;
      else return v[31:0];
   endfunction

endpackage

/* sv/lbs_palette_ram.sv */
// Palette store: single-port-write, single-read synchronous RAM with a registered read.
// Depends on nothing; depth and address width come from the top level.
module lbs_palette_ram #(
   parameter int DEPTH = 768,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/lbs_row_unit.sv */
// Row datapath: one matrix word times one coordinate per cycle, row sum with
// saturation, then the weight product. Depends on lbs_pkg.
module lbs_row_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  lbs_pkg::lbs_tag_type               rd_tag,
   input  logic [31:0]                        rd_data,
   input  logic                               jnt_ok,
   input  logic signed [31:0]                 pos_x,
   input  logic signed [31:0]                 pos_y,
   input  logic signed [31:0]                 pos_z,
   input  logic [lbs_pkg::LBS_WEIGHT_W-1:0]   weight,
   output lbs_pkg::lbs_tag_type               wt_tag,
   output logic signed [lbs_pkg::LBS_WPROD_W-1:0] wt_prod
);
   import lbs_pkg::*;

   logic signed [31:0]          word;
   logic signed [31:0]          coord;
   logic signed [63:0]          prod_in;
   logic signed [63:0]          prod_ff;
   lbs_tag_type                 prod_tag_ff;
   logic signed [63:0]          prod_rnd;
   logic signed [LBS_ACC_W-1:0] term;
   logic signed [LBS_SUM_W-1:0] sum_in;
   logic signed [LBS_SUM_W-1:0] sum_ff;
   logic signed [LBS_ACC_W-1:0] t_ff;
   lbs_tag_type                 t_tag_ff;
   logic signed [LBS_WPROD_W-1:0] wprod_ff;
   lbs_tag_type                 wprod_tag_ff;

   // An out-of-range joint reads as an all-zero matrix.
   assign word = jnt_ok ? $signed(rd_data) : 32'sd0;

   // The translation word goes through the same multiplier scaled by one, so
   // rounding it back to Q16.16 returns it unchanged.
   always_comb begin
      case (rd_tag.col)
         2'd0:    coord = pos_x;
         2'd1:    coord = pos_y;
         2'd2:    coord = pos_z;
         default: coord = LBS_Q16_ONE;
      endcase
   end

   assign prod_in  = 64'(word) * 64'(coord);
   assign prod_rnd = prod_ff + 64'sd32768;
   assign term     = prod_rnd[63:16];

   always_comb begin
      if (prod_tag_ff.col == LBS_COL_FIRST) begin
         sum_in = LBS_SUM_W'(term);
      end else begin
         sum_in = sum_ff + LBS_SUM_W'(term);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      wprod_ff <= LBS_WPROD_W'(t_ff) * $signed({1'b0, weight});
      if (prod_tag_ff.vld) begin
         sum_ff <= sum_in;
      end
      if (prod_tag_ff.vld && prod_tag_ff.col == LBS_COL_TRANS) begin
         t_ff <= sat48(sum_in);
      end
      if (reset) begin
         prod_tag_ff  <= '0;
         t_tag_ff     <= '0;
         wprod_tag_ff <= '0;
      end else begin
         prod_tag_ff  <= rd_tag;
         t_tag_ff     <= '{vld: prod_tag_ff.vld && prod_tag_ff.col == LBS_COL_TRANS,
                           row: prod_tag_ff.row, col: prod_tag_ff.col};
         wprod_tag_ff <= t_tag_ff;
      end
   end

   assign wt_tag  = wprod_tag_ff;
   assign wt_prod = wprod_ff;

endmodule

/* sv/linear_blend_skinning.sv */
// Vertex skinning engine, top level: handshake, read sequencer, accumulators
// and result register. Depends on lbs_pkg, lbs_palette_ram and lbs_row_unit.
//
// Usage:
//   The request channel carries two kinds of transfer, chosen by req_tuser.
//   A palette write (req_tuser = 0) stores one word of a joint's 3x4 matrix.
//   An influence (req_tuser = 1) transforms the vertex position by the
//   joint's matrix, scales it by the weight and adds it to the x/y/z
//   accumulators. An influence with req_tlast set also sends the saturated
//   position on the response channel and clears the accumulators.
//   An influence occupies the block while the 12 matrix words are read one
//   per cycle from the single read port of the palette RAM and while the
//   multiply, row-sum, weight and accumulate stages drain. A last influence
//   then loads the response register from its EMIT state.
//   The result waits in the response register while the receiver stalls;
//   the next request is accepted meanwhile, and only a following last
//   influence holds in its final cycle until the register is free.
//   Reset clears the accumulators and all control state. Palette contents
//   are undefined until written.
module linear_blend_skinning #(
   parameter int JOINT_COUNT = lbs_pkg::LBS_JOINT_COUNT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // joint, element, word_value, pos_x, pos_y, pos_z, weight, zero fill
   input  logic [lbs_pkg::LBS_REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic                               req_tuser,
   // last_influence
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_x, out_y, out_z
   output logic [lbs_pkg::LBS_RSP_DATA_W-1:0] rsp_tdata
);
   import lbs_pkg::*;

   localparam int DEPTH = JOINT_COUNT * LBS_MAT_WORDS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW    = (AW > 10) ? AW : 10;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [LBS_JOINT_W-1:0]  req_joint;
   logic [LBS_ELEM_W-1:0]   req_element;
   logic [31:0]             req_word;
   logic [LBS_WEIGHT_W-1:0] req_weight;
   logic                    accept;

   logic [1:0]              state_ff, state_in;
   logic [LBS_JOINT_W-1:0]  joint_ff;
   logic                    jnt_ok_ff;
   logic signed [31:0]      pos_x_ff, pos_y_ff, pos_z_ff;
   logic [LBS_WEIGHT_W-1:0] weight_ff;
   logic                    last_ff;
   logic                    iss_vld_ff, iss_vld_in;
   logic [3:0]              iss_cnt_ff, iss_cnt_in;
   lbs_tag_type             rd_tag_ff;

   logic                    wr_en;
   logic [FW-1:0]           wr_full;
   logic [FW-1:0]           rd_full;
   logic [31:0]             rd_data;

   lbs_tag_type                   wt_tag;
   logic signed [LBS_WPROD_W-1:0] wt_prod;
   logic signed [LBS_WPROD_W-1:0] wt_rnd;
   logic signed [LBS_SUM_W-1:0]   wt_val;

   logic signed [LBS_ACC_W-1:0] acc_x_ff, acc_y_ff, acc_z_ff;
   logic signed [LBS_ACC_W-1:0] acc_x_in, acc_y_in, acc_z_in;
   logic                        rsp_tvalid_ff, rsp_tvalid_in;
   logic [LBS_RSP_DATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;
   logic                        emit;

   assign req_joint   = req_tdata[5:0];
   assign req_element = req_tdata[9:6];
   assign req_word    = req_tdata[41:10];
   assign req_weight  = req_tdata[154:138];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Palette writes land at the transfer edge; an influence only starts
   // reading after that edge, so reads never overlap a pending write.
   assign wr_en   = accept && req_tuser == LBS_MODE_WRITE
                    && 32'(req_joint) < JOINT_COUNT && req_element < 4'(LBS_MAT_WORDS);
   assign wr_full = FW'(req_joint) * FW'(LBS_MAT_WORDS) + FW'(req_element);
   assign rd_full = FW'(joint_ff) * FW'(LBS_MAT_WORDS) + FW'(iss_cnt_ff);

   lbs_palette_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_full[AW-1:0]),
      .wr_data (req_word),
      .rd_addr (rd_full[AW-1:0]),
      .rd_data (rd_data)
   );

   lbs_row_unit u_row (
      .clock   (clock),
      .reset   (reset),
      .rd_tag  (rd_tag_ff),
      .rd_data (rd_data),
      .jnt_ok  (jnt_ok_ff),
      .pos_x   (pos_x_ff),
      .pos_y   (pos_y_ff),
      .pos_z   (pos_z_ff),
      .weight  (weight_ff),
      .wt_tag  (wt_tag),
      .wt_prod (wt_prod)
   );

   assign wt_rnd = wt_prod + LBS_WPROD_W'(32768);
   assign wt_val = LBS_SUM_W'($signed(wt_rnd[LBS_WPROD_W-1:16]));
   assign emit   = (state_ff == ST_EMIT) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      state_in   = state_ff;
      iss_vld_in = iss_vld_ff;
      iss_cnt_in = iss_cnt_ff;
      acc_x_in   = acc_x_ff;
      acc_y_in   = acc_y_ff;
      acc_z_in   = acc_z_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      if (accept && req_tuser == LBS_MODE_APPLY) begin
         state_in   = ST_RUN;
         iss_vld_in = 1'b1;
         iss_cnt_in = 4'd0;
      end

      if (iss_vld_ff) begin
         iss_cnt_in = iss_cnt_ff + 4'd1;
         if (iss_cnt_ff == 4'(LBS_MAT_WORDS - 1)) begin
            iss_vld_in = 1'b0;
         end
      end

      if (wt_tag.vld) begin
         case (wt_tag.row)
            LBS_ROW_X: acc_x_in = sat48(LBS_SUM_W'(acc_x_ff) + wt_val);
            LBS_ROW_Y: acc_y_in = sat48(LBS_SUM_W'(acc_y_ff) + wt_val);
            default:   acc_z_in = sat48(LBS_SUM_W'(acc_z_ff) + wt_val);
         endcase
         if (wt_tag.row == LBS_ROW_Z) begin
            state_in = last_ff ? ST_EMIT : ST_IDLE;
         end
      end

      if (emit) begin
         rsp_tdata_in  = {sat32(acc_z_ff), sat32(acc_y_ff), sat32(acc_x_ff)};
         rsp_tvalid_in = 1'b1;
         acc_x_in      = '0;
         acc_y_in      = '0;
         acc_z_in      = '0;
         state_in      = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      if (accept && req_tuser == LBS_MODE_APPLY) begin
         joint_ff  <= req_joint;
         jnt_ok_ff <= 32'(req_joint) < JOINT_COUNT;
         pos_x_ff  <= $signed(req_tdata[73:42]);
         pos_y_ff  <= $signed(req_tdata[105:74]);
         pos_z_ff  <= $signed(req_tdata[137:106]);
         weight_ff <= (req_weight > LBS_WEIGHT_ONE) ? LBS_WEIGHT_ONE : req_weight;
         last_ff   <= req_tlast;
      end
      if (reset) begin
         state_ff      <= ST_IDLE;
         iss_vld_ff    <= 1'b0;
         iss_cnt_ff    <= 4'd0;
         rd_tag_ff     <= '0;
         acc_x_ff      <= '0;
         acc_y_ff      <= '0;
         acc_z_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         iss_vld_ff    <= iss_vld_in;
         iss_cnt_ff    <= iss_cnt_in;
         rd_tag_ff     <= '{vld: iss_vld_ff, row: iss_cnt_ff[3:2], col: iss_cnt_ff[1:0]};
         acc_x_ff      <= acc_x_in;
         acc_y_ff      <= acc_y_in;
         acc_z_ff      <= acc_z_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // A new response always leaves the accumulators cleared.
   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      emit |=> acc_x_ff == '0 && acc_y_ff == '0 && acc_z_ff == '0 && rsp_tvalid_ff)
      else $error("accumulators not cleared on response load");

   // The read sequencer never runs past the last matrix word.
   a_iss_range: assert property (@(posedge clock) disable iff (reset)
      iss_vld_ff |-> iss_cnt_ff < 4'(LBS_MAT_WORDS) && state_ff == ST_RUN)
      else $error("read sequencer out of range");

   // Accumulator updates only happen while an influence is in flight.
   a_wt_busy: assert property (@(posedge clock) disable iff (reset)
      wt_tag.vld |-> state_ff == ST_RUN && !req_tready)
      else $error("accumulate stage active outside an influence");

endmodule

/* verif/tb.sv */
// Self-checking testbench for the linear_blend_skinning vertex skinning engine.
// Holds its own palette and accumulator predictor and compares every response
// transfer against it. Depends on lbs_pkg and the linear_blend_skinning RTL.
module tb;
   import lbs_pkg::*;

   localparam int LIMIT_CYCLES = 600000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic                    mode;
      logic [LBS_JOINT_W-1:0]  joint;
      logic [LBS_ELEM_W-1:0]   element;
      logic [31:0]             word_value;
      logic [31:0]             pos_x;
      logic [31:0]             pos_y;
      logic [31:0]             pos_z;
      logic [LBS_WEIGHT_W-1:0] weight;
      logic                    last;
   } skin_item_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } skinned_pos_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // joint, element, word_value, pos_x, pos_y, pos_z, weight, zero fill
   logic [LBS_REQ_DATA_W-1:0] req_tdata = '0;
   // mode
   logic                      req_tuser = 1'b0;
   // last_influence
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // out_x, out_y, out_z
   logic [LBS_RSP_DATA_W-1:0] rsp_tdata;

   linear_blend_skinning dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   skin_item_type     pending_items[$];
   skinned_pos_type   expected_positions[$];
   skin_item_type     driven_item;
   skinned_pos_type   want_pos;
   logic signed [31:0] joint_palette [0:LBS_JOINT_COUNT*LBS_MAT_WORDS-1];
   logic signed [79:0] skin_acc [0:2] = '{80'sd0, 80'sd0, 80'sd0};
   bit                palette_loaded [0:LBS_JOINT_COUNT*LBS_MAT_WORDS-1];
   int                stim_count = 0;
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                tx_idle_pct = 0;
   int                rx_idle_pct = 0;
   int                hold_token = 0;
   int                hold_seen = 0;
   int                hold_left = 0;

   function automatic logic signed [79:0] clamp_bits(input logic signed [79:0] v,
                                                     input int bits);
      logic signed [79:0] hi;
      logic signed [79:0] lo;
      hi = (80'sd1 <<< (bits - 1)) - 80'sd1;
      lo = -hi - 80'sd1;
      if (v > hi) return hi;
      else if (v < lo) return lo;
      else return v;
   endfunction

   // Product of two Q16.16 style operands, rounded half up back to 16 fraction bits.
   function automatic logic signed [79:0] mul_round(input logic signed [79:0] a,
                                                    input logic signed [79:0] b);
      logic signed [79:0] p;
      p = a * b + 80'sd32768;
      return p >>> 16;
   endfunction

   task automatic skin_transfer(input skin_item_type it);
      int                 base;
      int                 r;
      logic signed [79:0] w;
      logic signed [79:0] t;
      logic signed [79:0] q [0:2];
      skinned_pos_type    pos;
      if (it.mode == LBS_MODE_WRITE) begin
         if (it.element < LBS_MAT_WORDS)
            joint_palette[int'(it.joint) * LBS_MAT_WORDS + it.element] = it.word_value;
      end else begin
         w = (it.weight > LBS_WEIGHT_ONE) ? LBS_WEIGHT_ONE : it.weight;
         for (r = 0; r < 3; r++) begin
            base = int'(it.joint) * LBS_MAT_WORDS + r * 4;
            t = mul_round(joint_palette[base], $signed(it.pos_x))
              + mul_round(joint_palette[base + 1], $signed(it.pos_y))
              + mul_round(joint_palette[base + 2], $signed(it.pos_z))
              + joint_palette[base + 3];
            t = mul_round(clamp_bits(t, LBS_ACC_W), w);
            skin_acc[r] = clamp_bits(skin_acc[r] + t, LBS_ACC_W);
         end
         if (it.last) begin
            for (r = 0; r < 3; r++) begin
               q[r] = clamp_bits(skin_acc[r], 32);
               skin_acc[r] = 80'sd0;
            end
            pos.x = q[0][31:0];
            pos.y = q[1][31:0];
            pos.z = q[2][31:0];
            expected_positions.push_back(pos);
         end
      end
   endtask

   function automatic skin_item_type make_item(input logic mode, input int joint,
                                               input int element, input logic [31:0] word,
                                               input logic [31:0] x, input logic [31:0] y,
                                               input logic [31:0] z, input int weight,
                                               input logic last);
      skin_item_type it;
      it.mode       = mode;
      it.joint      = joint[LBS_JOINT_W-1:0];
      it.element    = element[LBS_ELEM_W-1:0];
      it.word_value = word;
      it.pos_x      = x;
      it.pos_y      = y;
      it.pos_z      = z;
      it.weight     = weight[LBS_WEIGHT_W-1:0];
      it.last       = last;
      return it;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(7))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0;
               default: return LBS_Q16_ONE;
            endcase
         end
         3, 4: return int'($urandom_range(262143)) - 131072;
         default: return int'($urandom_range(33554431)) - 16777216;
      endcase
   endfunction

   function automatic int rand_weight();
      case ($urandom_range(7))
         0: return 0;
         1: return LBS_WEIGHT_ONE;
         2: return $urandom_range(131071, 65537);
         default: return $urandom_range(65536);
      endcase
   endfunction

   task automatic add_item(input skin_item_type it);
      pending_items.push_back(it);
      if (it.mode == LBS_MODE_WRITE && it.element < LBS_MAT_WORDS)
         palette_loaded[int'(it.joint) * LBS_MAT_WORDS + it.element] = 1'b1;
      if (it.mode == LBS_MODE_APPLY || it.element < LBS_MAT_WORDS)
         stim_count++;
   endtask

   // One vertex: a run of influences sharing a position that may be redrawn between
   // them, the final one flagged. Every matrix word a joint needs is written before the joint is used.
   task automatic gen_vertex(input int max_influences);
      int          n;
      int          k;
      int          e;
      int          j;
      bit          empty_vertex;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      empty_vertex = ($urandom_range(19) == 0);
      n = empty_vertex ? 1 : $urandom_range(max_influences, 1);
      x = rand_word();
      y = rand_word();
      z = rand_word();
      for (k = 0; k < n; k++) begin
         j = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7);
         for (e = 0; e < LBS_MAT_WORDS; e++) begin
            if (!palette_loaded[j * LBS_MAT_WORDS + e])
               add_item(make_item(LBS_MODE_WRITE, j, e, rand_word(), $urandom, $urandom,
                                  $urandom, $urandom_range(131071),
                                  1'($urandom_range(1))));
         end
         if ($urandom_range(11) == 0)
            add_item(make_item(LBS_MODE_WRITE, $urandom_range(63), $urandom_range(15),
                               rand_word(), $urandom, $urandom, $urandom,
                               $urandom_range(131071), 1'b1));
         if ($urandom_range(19) == 0) begin
            x = rand_word();
            y = rand_word();
            z = rand_word();
         end
         add_item(make_item(LBS_MODE_APPLY, j, $urandom_range(15), $urandom, x, y, z,
                            empty_vertex ? 0 : rand_weight(), k == n - 1));
      end
   endtask

   task automatic gen_phase(input int target);
      int r;
      while (stim_count < target) begin
         r = $urandom_range(99);
         if (r < 10)
            add_item(make_item(LBS_MODE_WRITE, $urandom_range(63), $urandom_range(15),
                               rand_word(), $urandom, $urandom, $urandom,
                               $urandom_range(131071), 1'($urandom_range(1))));
         else if (r < 15)
            gen_vertex(10);
         else
            gen_vertex(4);
      end
   endtask

   // Checked at the falling edge so that all transfers of the cycle have settled.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_positions.size() != 0)
         @(negedge clock);
   endtask

   // Request driver: predicts each accepted transfer, then offers the next item.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            skin_transfer(driven_item);
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               driven_item = pending_items.pop_front();
               req_tdata  <= {5'd0, driven_item.weight, driven_item.pos_z,
                              driven_item.pos_y, driven_item.pos_x,
                              driven_item.word_value, driven_item.element,
                              driven_item.joint};
               req_tuser  <= driven_item.mode;
               req_tlast  <= driven_item.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response receiver, with a long hold-off whenever a new one is requested.
   always @(posedge clock) begin
      if (hold_seen != hold_token) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_positions.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected response transfer: x=%h y=%h z=%h",
                        rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64]);
         end else begin
            want_pos = expected_positions.pop_front();
            if (rsp_tdata[31:0] !== want_pos.x || rsp_tdata[63:32] !== want_pos.y ||
                rsp_tdata[95:64] !== want_pos.z) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("position mismatch: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                           want_pos.x, want_pos.y, want_pos.z, rsp_tdata[31:0],
                           rsp_tdata[63:32], rsp_tdata[95:64]);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int e;
      tx_idle_pct = 19;
      rx_idle_pct = 66;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Identity matrix on joint 0.
      for (e = 0; e < LBS_MAT_WORDS; e++)
         add_item(make_item(LBS_MODE_WRITE, 0, e,
                            (e == 0 || e == 5 || e == 10) ? LBS_Q16_ONE : 32'h0,
                            0, 0, 0, 0, 1'b0));
      // Out-of-range element with the last flag: no effect at all.
      add_item(make_item(LBS_MODE_WRITE, 0, 13, 32'h7fff_ffff, 0, 0, 0, 0, 1'b1));
      // Vertex whose only influence has zero weight.
      add_item(make_item(LBS_MODE_APPLY, 0, 0, 0, 0, 0, 0, 0, 1'b1));
      add_item(make_item(LBS_MODE_APPLY, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h7fff_ffff, LBS_WEIGHT_ONE, 1'b1));
      // Weight above one is clamped to one.
      add_item(make_item(LBS_MODE_APPLY, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 131071, 1'b1));
      // Two full influences overflow the 32-bit output.
      add_item(make_item(LBS_MODE_APPLY, 0, 0, 0, 32'h7fff_ffff, 32'h1234_5678,
                         32'h8000_0000, LBS_WEIGHT_ONE, 1'b0));
      add_item(make_item(LBS_MODE_APPLY, 0, 0, 0, 32'h7fff_ffff, 32'h1234_5678,
                         32'h8000_0000, LBS_WEIGHT_ONE, 1'b1));
      // Most negative words in row x drive the row sum and the accumulator
      // into 48-bit saturation.
      for (e = 0; e < 3; e++)
         add_item(make_item(LBS_MODE_WRITE, 0, e, 32'h8000_0000, 0, 0, 0, 0, 1'b0));
      for (e = 0; e < 3; e++)
         add_item(make_item(LBS_MODE_APPLY, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, LBS_WEIGHT_ONE, e == 2));
      wait_drained();

      gen_phase(540);
      wait_drained();

      tx_idle_pct = 66;
      rx_idle_pct = 19;
      gen_phase(1060);
      wait_drained();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_token = hold_token + 1;
      gen_phase(1580);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      mismatch_count += expected_positions.size();
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* linear_blend_skinning.f */
sv/lbs_pkg.sv
sv/lbs_palette_ram.sv
sv/lbs_row_unit.sv
sv/linear_blend_skinning.sv
verif/tb.sv
